### src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int unsigned LengthBitsDefault = 64;

	localparam logic [1:0] REQ_DATA     = 2'd0;
	localparam logic [1:0] REQ_DATA_END = 2'd1;
	localparam logic [1:0] REQ_END      = 2'd2;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  PAD_LIMIT = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} md5_state_t;

	// controller to datapath
	typedef struct packed {
		logic take_byte;   // write byte into block, bump count
		logic start_round; // load working words from chain
		logic do_round;    // run one round
		logic fold;        // add working words into chain
		logic pad_mark;    // write 0x80 and clear tail
		logic clear_all;   // clear block words 0 to 13
		logic put_len;     // write length words
		logic rearm;       // restore chain and count
		logic load_out;    // capture digest
	} md5_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full_block; // byte just taken filled the block
		logic last_round; // round counter at 63
		logic pad_two;    // padding needs a second block
		logic len_done;   // length block has been loaded
	} md5_stat_t;

	function automatic logic [31:0] round_k(input logic [5:0] j);
		logic [31:0] k;
		case (j)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] j);
		logic [4:0] s;
		case ({j[5:4], j[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

### src/md5_ctrl.sv
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer for byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        req_type,
	input  logic              out_stall,
	input  md5_pkg::md5_stat_t stat,
	output logic              in_stall,
	output logic              out_valid,
	output md5_pkg::md5_cmd_t cmd
);

	md5_pkg::md5_state_t state_q, state_d;
	logic ending_q, ending_d; // current compression belongs to the end sequence
	logic second_q, second_d; // a length-only block still follows
	logic acc;

	assign acc = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d  = state_q;
		ending_d = ending_q;
		second_d = second_q;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				if (acc) begin
					if (req_type == md5_pkg::REQ_DATA) begin
						if (stat.full_block) begin
							state_d = md5_pkg::ST_ROUND;
							ending_d = 1'b0;
						end
					end else if (req_type == md5_pkg::REQ_DATA_END) begin
						ending_d = 1'b1;
						state_d = stat.full_block ? md5_pkg::ST_ROUND : md5_pkg::ST_PAD;
					end else if (req_type == md5_pkg::REQ_END) begin
						ending_d = 1'b1;
						state_d = md5_pkg::ST_PAD;
					end
				end
			end
			md5_pkg::ST_ROUND: if (stat.last_round) state_d = md5_pkg::ST_FOLD;
			md5_pkg::ST_FOLD: begin
				if (!ending_q) state_d = md5_pkg::ST_IDLE;
				else if (second_q) state_d = md5_pkg::ST_LEN;
				else if (stat.len_done) state_d = md5_pkg::ST_OUT;
				else state_d = md5_pkg::ST_PAD;
			end
			md5_pkg::ST_PAD: begin
				second_d = stat.pad_two;
				state_d = stat.pad_two ? md5_pkg::ST_ROUND : md5_pkg::ST_LEN;
			end
			md5_pkg::ST_LEN: begin
				second_d = 1'b0;
				state_d = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = md5_pkg::ST_IDLE;
					ending_d = 1'b0;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take_byte = acc && (req_type == md5_pkg::REQ_DATA
					|| req_type == md5_pkg::REQ_DATA_END);
				cmd.start_round = acc && ((stat.full_block && (req_type == md5_pkg::REQ_DATA
					|| req_type == md5_pkg::REQ_DATA_END)));
			end
			md5_pkg::ST_ROUND: cmd.do_round = 1'b1;
			md5_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				cmd.load_out = ending_q && !second_q && stat.len_done;
			end
			md5_pkg::ST_PAD: begin
				cmd.pad_mark = 1'b1;
				cmd.start_round = stat.pad_two;
			end
			md5_pkg::ST_LEN: begin
				cmd.put_len = 1'b1;
				cmd.clear_all = second_q;
				cmd.start_round = 1'b1;
			end
			md5_pkg::ST_OUT: begin
				out_valid = 1'b1;
				cmd.rearm = !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= md5_pkg::ST_IDLE;
			ending_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ending_q <= ending_d;
			second_q <= second_d;
		end
	end

endmodule

### src/md5_dpath.sv
// ----------------------------------------------------------------------------
// md5_dpath
// Block buffer, byte counter, chaining words and one-round-per-cycle core.
// ----------------------------------------------------------------------------
module md5_dpath #(
	parameter int unsigned LENGTH_BITS = md5_pkg::LengthBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::md5_cmd_t cmd,
	input  logic [7:0]        data_byte,
	output md5_pkg::md5_stat_t stat,
	output logic [63:0]       digest_high,
	output logic [63:0]       digest_low
);

	logic [31:0] blk_q [16];
	logic [63:0] count_q;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [5:0]  rnd_q;
	logic        len_done_q; // length words have been written into the block
	logic [63:0] dh_q, dl_q;

	logic [5:0]  pos;
	logic [3:0]  g;
	logic [31:0] f, sum, rot;
	logic [4:0]  sh;
	logic [63:0] bits;

	assign pos = count_q[5:0];
	assign bits = (count_q << 3) & ({64{1'b1}} >> (64 - LENGTH_BITS));

	// round function and message index
	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f = (wb_q & wc_q) | (~wb_q & wd_q);
				g = rnd_q[3:0];
			end
			2'd1: begin
				f = (wd_q & wb_q) | (~wd_q & wc_q);
				g = 4'(5 * rnd_q + 1);
			end
			2'd2: begin
				f = wb_q ^ wc_q ^ wd_q;
				g = 4'(3 * rnd_q + 5);
			end
			default: begin
				f = wc_q ^ (wb_q | ~wd_q);
				g = 4'(7 * rnd_q);
			end
		endcase
		sum = f + wa_q + md5_pkg::round_k(rnd_q) + blk_q[g];
		sh  = md5_pkg::round_s(rnd_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	assign stat.full_block = (pos == 6'd63);
	assign stat.last_round = (rnd_q == 6'd63);
	assign stat.pad_two    = (pos >= md5_pkg::PAD_LIMIT);
	assign stat.len_done   = len_done_q;

	// block buffer
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= data_byte;
		end
		if (cmd.pad_mark) begin
			for (int i = 0; i < 16; i++) begin
				if (i > int'(pos[5:2])) blk_q[i] <= '0;
			end
			for (int b = 0; b < 4; b++) begin
				if (b == int'(pos[1:0])) blk_q[pos[5:2]][b*8 +: 8] <= md5_pkg::PAD_BYTE;
				else if (b > int'(pos[1:0])) blk_q[pos[5:2]][b*8 +: 8] <= '0;
			end
		end
		if (cmd.clear_all) begin
			for (int i = 0; i < 14; i++) blk_q[i] <= '0;
		end
		if (cmd.put_len) begin
			blk_q[14] <= bits[31:0];
			blk_q[15] <= bits[63:32];
		end
	end

	// counters, chain and length flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ca_q <= md5_pkg::INIT_A;
			cb_q <= md5_pkg::INIT_B;
			cc_q <= md5_pkg::INIT_C;
			cd_q <= md5_pkg::INIT_D;
			rnd_q <= '0;
			len_done_q <= 1'b0;
		end else begin
			if (cmd.take_byte) count_q <= count_q + 64'd1;
			if (cmd.put_len) len_done_q <= 1'b1;
			if (cmd.do_round) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold) begin
				ca_q <= ca_q + wa_q;
				cb_q <= cb_q + wb_q;
				cc_q <= cc_q + wc_q;
				cd_q <= cd_q + wd_q;
			end
			if (cmd.rearm) begin
				count_q <= '0;
				ca_q <= md5_pkg::INIT_A;
				cb_q <= md5_pkg::INIT_B;
				cc_q <= md5_pkg::INIT_C;
				cd_q <= md5_pkg::INIT_D;
				len_done_q <= 1'b0;
			end
		end
	end

	// working words
	always_ff @(posedge clk) begin
		if (cmd.start_round) begin
			wa_q <= ca_q;
			wb_q <= cb_q;
			wc_q <= cc_q;
			wd_q <= cd_q;
		end else if (cmd.do_round) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= wb_q + rot;
		end
	end

	// digest capture
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			dh_q <= {md5_pkg::swap32(ca_q + wa_q), md5_pkg::swap32(cb_q + wb_q)};
			dl_q <= {md5_pkg::swap32(cc_q + wc_q), md5_pkg::swap32(cd_q + wd_q)};
		end
	end

	assign digest_high = dh_q;
	assign digest_low  = dl_q;

endmodule

### src/md5_message_digest_top.sv
// A data word that fills a block starts 64 rounds, then a fold and a return to idle.
// Other data words are taken without a stall. An end word leads through padding, an
// optional second block and the length block to the digest, with one MD5 round per
// cycle in the shared round unit. Input is stalled outside idle.
// Reset: arst_n clears count, rearms chaining words; block buffer is unset until written.
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest of a byte stream with standard padding.
// ----------------------------------------------------------------------------
module md5_message_digest_top #(
	parameter int unsigned LENGTH_BITS = md5_pkg::LengthBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_high,
	output logic [63:0] digest_low
);

	md5_pkg::md5_cmd_t  cmd;
	md5_pkg::md5_stat_t stat;

	md5_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .req_type(req_type),
		.out_stall(out_stall), .stat(stat), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	md5_dpath #(.LENGTH_BITS(LENGTH_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.stat(stat), .digest_high(digest_high), .digest_low(digest_low)
	);

	// never accept while a digest waits
	a_no_in_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while digest pending");

	// a taken digest clears output next cycle
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("digest repeated");

	// fold and round never together
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fold && cmd.do_round)) else $error("fold during round");

endmodule
